// ===== src/mms_pkg.sv =====
// Package for the min/max selection sorter.
// Holds parameter defaults and the port width; no dependencies.
package mms_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int PORT_WIDTH      = 32;

endpackage

// ===== src/mms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used as the element store of the sorter; depends on nothing.
module mms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/min_max_selection_sorter_unit.sv =====
// Top level of the min/max selection sorter: load, double-ended selection sort, emit.
// Depends on mms_pkg and mms_ram.

// A set of values is loaded one request at a time (s_ready high) until a request
// with s_last arrives; requests beyond CAPACITY are dropped and the set is
// flagged as overflowed. The set is then sorted in place in a single-write,
// single-read element RAM by one shared min/max compare unit: each pass over a
// span of m entries reads one entry per cycle and then writes the two swaps (min
// slot, low end, max slot, high end). The sorted values are then sent out one at
// a time: read, load output register, hand over while m_ready is high; the next
// value is read only after the last is taken. s_ready stays low from the last
// request of a set until its final result is taken. The element store has no
// reset; only entries written in the current set are read.
module min_max_selection_sorter_unit
    import mms_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [PORT_WIDTH-1:0] s_value,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [PORT_WIDTH-1:0] m_sorted_value,
    output logic                         m_end_of_set,
    output logic                         m_overflowed
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = VALUE_WIDTH;

    // Sequencer codes
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SCAN     = 4'd1;
    localparam logic [3:0] ST_SCAN_END = 4'd2;
    localparam logic [3:0] ST_WR_MIN   = 4'd3;
    localparam logic [3:0] ST_WR_LO    = 4'd4;
    localparam logic [3:0] ST_WR_MAX   = 4'd5;
    localparam logic [3:0] ST_WR_HI    = 4'd6;
    localparam logic [3:0] ST_EM_RD    = 4'd7;
    localparam logic [3:0] ST_EM_LD    = 4'd8;
    localparam logic [3:0] ST_EM_OUT   = 4'd9;

    // Control registers
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;
    logic          rd_vld_reg, rd_vld_next;
    logic          m_valid_reg, m_valid_next;

    // Sequencer and payload registers
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [AW-1:0] min_idx_reg, min_idx_next;
    logic [AW-1:0] max_idx_reg, max_idx_next;
    logic [VW-1:0] min_val_reg, min_val_next;
    logic [VW-1:0] max_val_reg, max_val_next;
    logic [VW-1:0] vlo_reg, vlo_next;
    logic [VW-1:0] vhi_reg, vhi_next;
    logic signed [PORT_WIDTH-1:0] out_value_reg, out_value_next;
    logic          out_end_reg, out_end_next;

    // Element store port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [VW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [VW-1:0] mem_rdata;

    // Helpers
    logic [PORT_WIDTH+63:0] in_ext;
    logic [VW+63:0]         out_ext;
    logic                   store_full;
    logic [CW-1:0]          count_inc;
    logic [CW-1:0]          set_size;
    logic [AW-1:0]          max_idx_fix;
    logic [VW-1:0]          hi_after_min;
    logic [AW-1:0]          lo_inc;
    logic [AW-1:0]          hi_dec;
    logic                   k_is_last;
    logic                   s_fire;
    logic                   m_fire;

    mms_ram #(
        .WIDTH (VW),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Keep the low VALUE_WIDTH bits of the request; zero-fill above the port width.
    assign in_ext  = {64'd0, s_value};
    // Sign-extend the stored value and keep the port width.
    assign out_ext = {{64{mem_rdata[VW-1]}}, mem_rdata};

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid_reg && m_ready;

    assign store_full = (count_reg == CW'(CAPACITY));
    assign count_inc  = count_reg + CW'(1);
    assign set_size   = store_full ? count_reg : count_inc;

    // Swap bookkeeping: a max found at the pass start has moved to the min slot,
    // and the high end may have received the old low value.
    assign max_idx_fix  = (max_idx_reg == lo_reg) ? min_idx_reg : max_idx_reg;
    assign hi_after_min = (min_idx_reg == hi_reg) ? vlo_reg : vhi_reg;
    assign lo_inc       = lo_reg + AW'(1);
    assign hi_dec       = hi_reg - AW'(1);
    assign k_is_last    = ((CW'(k_reg) + CW'(1)) == count_reg);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        rd_vld_next  = 1'b0;
        m_valid_next = m_valid_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        rd_idx_next  = rd_idx_reg;
        min_idx_next = min_idx_reg;
        max_idx_next = max_idx_reg;
        min_val_next = min_val_reg;
        max_val_next = max_val_reg;
        vlo_next     = vlo_reg;
        vhi_next     = vhi_reg;
        out_value_next = out_value_reg;
        out_end_next   = out_end_reg;
        mem_we       = 1'b0;
        mem_waddr    = count_reg[AW-1:0];
        mem_wdata    = in_ext[VW-1:0];
        mem_raddr    = j_reg;

        // Shared min/max compare unit: fold in the entry read last cycle.
        if (rd_vld_reg) begin
            if (rd_idx_reg == lo_reg) begin
                min_val_next = mem_rdata;
                max_val_next = mem_rdata;
                min_idx_next = lo_reg;
                max_idx_next = lo_reg;
                vlo_next     = mem_rdata;
            end else if ($signed(mem_rdata) < $signed(min_val_reg)) begin
                min_val_next = mem_rdata;
                min_idx_next = rd_idx_reg;
            end else if ($signed(max_val_reg) < $signed(mem_rdata)) begin
                max_val_next = mem_rdata;
                max_idx_next = rd_idx_reg;
            end
            if (rd_idx_reg == hi_reg) begin
                vhi_next = mem_rdata;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    // Store while there is room, otherwise drop and flag.
                    if (!store_full) begin
                        mem_we     = 1'b1;
                        count_next = count_inc;
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_last) begin
                        lo_next = '0;
                        j_next  = '0;
                        hi_next = AW'(set_size - CW'(1));
                        k_next  = '0;
                        if (set_size > CW'(1)) begin
                            state_next = ST_SCAN;
                        end else begin
                            state_next = ST_EM_RD;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle across the unsorted span.
                mem_raddr   = j_reg;
                rd_vld_next = 1'b1;
                rd_idx_next = j_reg;
                if (j_reg == hi_reg) begin
                    state_next = ST_SCAN_END;
                end else begin
                    j_next = j_reg + AW'(1);
                end
            end
            ST_SCAN_END: begin
                state_next = ST_WR_MIN;
            end
            ST_WR_MIN: begin
                mem_we     = 1'b1;
                mem_waddr  = min_idx_reg;
                mem_wdata  = vlo_reg;
                state_next = ST_WR_LO;
            end
            ST_WR_LO: begin
                mem_we     = 1'b1;
                mem_waddr  = lo_reg;
                mem_wdata  = min_val_reg;
                state_next = ST_WR_MAX;
            end
            ST_WR_MAX: begin
                mem_we     = 1'b1;
                mem_waddr  = max_idx_fix;
                mem_wdata  = hi_after_min;
                state_next = ST_WR_HI;
            end
            ST_WR_HI: begin
                mem_we    = 1'b1;
                mem_waddr = hi_reg;
                mem_wdata = max_val_reg;
                lo_next   = lo_inc;
                hi_next   = hi_dec;
                j_next    = lo_inc;
                k_next    = '0;
                if (lo_inc < hi_dec) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_EM_RD;
                end
            end
            ST_EM_RD: begin
                mem_raddr  = k_reg;
                state_next = ST_EM_LD;
            end
            ST_EM_LD: begin
                out_value_next = out_ext[PORT_WIDTH-1:0];
                out_end_next   = k_is_last;
                m_valid_next   = 1'b1;
                state_next     = ST_EM_OUT;
            end
            ST_EM_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (out_end_reg) begin
                        // Set done: clear for the next set.
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        k_next     = k_reg + AW'(1);
                        state_next = ST_EM_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        rd_idx_reg    <= rd_idx_next;
        min_idx_reg   <= min_idx_next;
        max_idx_reg   <= max_idx_next;
        min_val_reg   <= min_val_next;
        max_val_reg   <= max_val_next;
        vlo_reg       <= vlo_next;
        vhi_reg       <= vhi_next;
        out_value_reg <= out_value_next;
        out_end_reg   <= out_end_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = out_value_reg;
    assign m_end_of_set   = out_end_reg;
    assign m_overflowed   = dropped_reg;

    // Loading and emitting never overlap.
    a_no_load_while_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid_reg))
        else $error("input ready while a result is pending");

    // The fill count never passes the store depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("element count beyond capacity");

    // A scan always covers a span of at least two entries.
    a_scan_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (lo_reg < hi_reg))
        else $error("scan with empty span");

    // Taking the final result returns the block to loading with an empty store.
    a_set_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && out_end_reg) |=> (s_ready && (count_reg == '0) && !dropped_reg))
        else $error("set not closed after final result");

endmodule
